>>> rtl/wbps_pkg.sv
// wbps_pkg: shared constants, register codes and the queue entry type
// of the wildcard byte pattern search; used by the front, queue, back and top level
`timescale 1ns / 1ps

package wbps_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int WIN_IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	localparam int BYTE_W    = 8;
	localparam int POS_W     = 32;
	localparam int CFG_W     = 64;
	localparam int WILD_W    = 16;
	localparam int LEN_W     = 5;
	localparam int CFG_IDX_W = 3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAT_LO = 3'd0,
		CFG_PAT_HI = 3'd1,
		CFG_WILD   = 3'd2,
		CFG_LEN    = 3'd3
	} cfg_reg_t;

	// one classified byte as handed from front to back
	typedef struct packed {
		logic             cand;
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] taken;
		logic             last;
	} wbps_entry_t;

endpackage

>>> rtl/wbps_front.sv
// wbps_front: configuration registers, byte window, position count and
// the masked window compare; depends on wbps_pkg
`timescale 1ns / 1ps

module wbps_front import wbps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic                 last_byte,
	input  logic                 q_full,
	output logic                 push,
	output wbps_entry_t          push_entry
);

	logic [CFG_W-1:0]  pat_lo_q;
	logic [CFG_W-1:0]  pat_hi_q;
	logic [WILD_W-1:0] wild_q;
	logic [LEN_W-1:0]  len_q;

	logic [BYTE_W-1:0] win_q  [MAX_PATTERN];
	logic [BYTE_W-1:0] win_nx [MAX_PATTERN];
	logic [POS_W-1:0]  pos_q;

	logic [2*CFG_W-1:0] pat_all;
	logic [LEN_W-1:0]   eff_len;
	logic [LEN_W-1:0]   idx [MAX_PATTERN];
	logic               win_ok;
	logic               sat;
	logic [POS_W-1:0]   taken;
	logic [POS_W-1:0]   eff_len_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			wild_q   <= '0;
			len_q    <= LEN_W'(1);
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_PAT_LO: pat_lo_q <= cfg_data;
				CFG_PAT_HI: pat_hi_q <= cfg_data;
				CFG_WILD:   wild_q   <= cfg_data[WILD_W-1:0];
				CFG_LEN:    len_q    <= cfg_data[LEN_W-1:0];
				default:    ;
			endcase
		end
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// window as it stands once this byte is shifted in, entry 0 newest
	always_comb begin
		win_nx[0] = data_byte;
		for (int i = 1; i < MAX_PATTERN; i++) begin
			win_nx[i] = win_q[i-1];
		end
	end

	assign pat_all     = {pat_hi_q, pat_lo_q};
	assign eff_len     = (len_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_q;
	assign eff_len_ext = POS_W'(eff_len);

	always_comb begin
		win_ok = 1'b1;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			idx[k] = eff_len - LEN_W'(1) - LEN_W'(k);
			if ((LEN_W'(k) < eff_len) && !wild_q[k]
				&& (win_nx[idx[k][WIN_IDX_W-1:0]] != pat_all[k*BYTE_W +: BYTE_W])) begin
				win_ok = 1'b0;
			end
		end
	end

	assign sat   = &pos_q;
	assign taken = pos_q + POS_W'(1);

	assign push_entry.cand  = !sat && (eff_len != '0) && (taken >= eff_len_ext) && win_ok;
	assign push_entry.start = taken - eff_len_ext;
	assign push_entry.taken = taken;
	assign push_entry.last  = last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (last_byte) begin
				pos_q <= '0;
			end else if (!sat) begin
				pos_q <= taken;
			end
		end
	end

	// only bytes of the current block are ever compared, so no clearing
	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				win_q[i] <= win_nx[i];
			end
		end
	end

endmodule

>>> rtl/wbps_queue.sv
// wbps_queue: short first-in first-out queue of classified bytes between
// front and back; depends on wbps_pkg
`timescale 1ns / 1ps

module wbps_queue import wbps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  wbps_entry_t push_entry,
	output logic        full,
	input  logic        pop,
	output logic        head_valid,
	output wbps_entry_t head
);

	wbps_entry_t       slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

endmodule

>>> rtl/wbps_back.sv
// wbps_back: non-overlap check, match count and the output register;
// depends on wbps_pkg
`timescale 1ns / 1ps

module wbps_back import wbps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  wbps_entry_t      head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [POS_W-1:0] match_offset,
	output logic [POS_W-1:0] match_ordinal,
	output logic             block_end
);

	logic             out_valid_q;
	logic [POS_W-1:0] nas_q;
	logic [POS_W-1:0] cnt_q;
	logic [POS_W-1:0] offset_q;
	logic [POS_W-1:0] ordinal_q;
	logic             end_q;
	logic             hit;

	assign pop = head_valid && (!out_valid_q || !out_stall);
	assign hit = head.cand && (head.start >= nas_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			nas_q       <= '0;
			cnt_q       <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= hit;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (head.last) begin
					nas_q <= '0;
					cnt_q <= '0;
				end else if (hit) begin
					nas_q <= head.taken;
					cnt_q <= cnt_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && hit) begin
			offset_q  <= head.start;
			ordinal_q <= cnt_q;
			end_q     <= head.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign match_offset  = offset_q;
	assign match_ordinal = ordinal_q;
	assign block_end     = end_q;

endmodule

>>> rtl/wildcard_byte_pattern_search.sv
// wildcard_byte_pattern_search: top level of the wildcard byte pattern search
// depends on wbps_pkg, wbps_front, wbps_queue and wbps_back
`timescale 1ns / 1ps

// usage
// - input channel: one byte of the searched block per request (data_byte),
//   last_byte marks the final byte; a request is taken when in_valid is high
//   and in_stall is low
// - output channel: one request per match found, giving the start offset,
//   the number of earlier matches in the block and whether the match ends on
//   the last byte; matches are leftmost and never overlap
// - configuration: plain write port, cfg_index 0/1 pattern bytes low/high,
//   2 wildcard mask, 3 pattern length; other indexes are ignored; write only
//   while no request is in flight
// - throughput: one byte per cycle while in_stall is low, set by the
//   combinational masked compare of the sixteen-byte window in the front
// - output path: the classified byte is written into the queue, and the back
//   registers a match into the output register when it pops that entry from
//   the queue
// - stalling: out_stall holds a valid output request and the back stops
//   draining the four-entry queue; in_stall rises once the queue is full
// - reset: clears registers to their defaults (pattern length one), position,
//   match count and the queue; no clearing pass is needed
// - a block shorter than the pattern gives no match; the position count
//   saturates and stops matching in very long blocks

module wildcard_byte_pattern_search import wbps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic                 last_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [POS_W-1:0]     match_offset,
	output logic [POS_W-1:0]     match_ordinal,
	output logic                 block_end
);

	// front to queue
	logic        push;
	wbps_entry_t push_entry;
	logic        q_full;

	// queue to back
	logic        pop;
	logic        head_valid;
	wbps_entry_t head;

	// front: registers, window, position and compare
	wbps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// decoupling queue, lets the back stall without stopping the front at once
	wbps_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// back: non-overlap rule, counting and output register
	wbps_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.match_offset  (match_offset),
		.match_ordinal (match_ordinal),
		.block_end     (block_end)
	);

endmodule

>>> rtl/wbps_checker.sv
// wbps_checker: assertions on the output ports of the search block and the
// bind that attaches them; depends on wildcard_byte_pattern_search
`timescale 1ns / 1ps

module wbps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] match_offset,
	input logic [31:0] match_ordinal,
	input logic        block_end
);

	logic        prev_valid_q;
	logic        prev_end_q;
	logic [31:0] prev_ord_q;
	logic [31:0] prev_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
			prev_end_q   <= 1'b0;
			prev_ord_q   <= '0;
			prev_off_q   <= '0;
		end else if (out_valid && !out_stall) begin
			prev_valid_q <= 1'b1;
			prev_end_q   <= block_end;
			prev_ord_q   <= match_ordinal;
			prev_off_q   <= match_offset;
		end
	end

	// nothing is offered in the cycle after reset is seen
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid during reset");

	// a stalled request holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(match_offset)
			&& $stable(match_ordinal) && $stable(block_end))
		else $error("stalled output request changed");

	// a match ending a block closes the count
	a_new_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && prev_valid_q && prev_end_q |-> match_ordinal == 32'd0)
		else $error("match count not restarted after block end");

	// within a block the count steps by one and offsets rise
	a_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && prev_valid_q && !prev_end_q && (match_ordinal != 32'd0)
			|-> (match_ordinal == prev_ord_q + 32'd1) && (match_offset > prev_off_q))
		else $error("match count or offset out of order");

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.match_offset  (match_offset),
	.match_ordinal (match_ordinal),
	.block_end     (block_end)
);
